FILE: hdl/stsi_pkg.sv
// shared types, constants and codes of the track spline interpolator
package stsi_pkg;

  localparam int unsigned VAL_W  = 32;  // Q16.16 sample and result width
  localparam int unsigned DATA_W = 64;  // internal arithmetic width
  localparam int unsigned DT_W   = 25;  // knot spacing, Q16.16, below 2^24 + 1
  localparam int unsigned IDX_W  = 13;  // row index, below the 13 bit sample count
  localparam int unsigned FRAC_W = 16;  // Q0.16 fraction
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned PER_W  = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned STEP_W = 6;

  localparam int unsigned MUL_STEPS  = 32;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned SQRT_STEPS = 32;

  localparam logic [PER_W-1:0] PERIOD_RESET = 16'd40;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic CFG_SAMPLE_COUNT  = 1'b0;
  localparam logic CFG_SAMPLE_PERIOD = 1'b1;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_e;

  typedef enum logic [1:0] {
    METH_NEAREST = 2'd0,
    METH_LINEAR  = 2'd1,
    METH_CR      = 2'd2
  } meth_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIV_T,
    S_DIV_F,
    S_RD_A,
    S_RD_B,
    S_RD_C,
    S_RD_D,
    S_RD_E,
    S_K_SQ,
    S_K_R1,
    S_K_R2,
    S_T1,
    S_T2,
    S_T3,
    S_T4,
    S_T5,
    S_T6,
    S_T7,
    S_T8,
    S_CO,
    S_H1,
    S_H2,
    S_H3,
    S_FIN
  } state_e;

  typedef struct packed {
    logic                     start;
    alu_op_e                  op;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] res;
    logic [DATA_W-1:0]        rem;
  } alu_rsp_t;

endpackage

FILE: hdl/sampled_track_spline_interpolator.sv
// sample table with query sequencer evaluating nearest, linear or centripetal spline
// a write item leaves the sequencer idle; a query with no samples or a bad channel goes
// straight to the output stage, and the other queries run their steps on the shared
// unit (multiply 32, divide 64, square root 32 steps)
// throughput: one item in flight; the next is taken once the result sits in the output register
// reset: sample count 0, period 40 ms; the sample table is not cleared and holds garbage
module sampled_track_spline_interpolator import stsi_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned CHANNELS    = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic [11:0]             sample_index_i,
  input  logic [2:0]              channel_i,
  input  logic signed [VAL_W-1:0] sample_value_i,
  input  logic [31:0]             query_time_ms_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [VAL_W-1:0] coordinate_o,
  output logic [1:0]              method_used_o
);

  localparam int unsigned DEPTH = MAX_SAMPLES * CHANNELS;
  localparam int unsigned AW    = $clog2(DEPTH);

  function automatic logic signed [DATA_W-1:0] rnd16(input logic signed [DATA_W-1:0] p);
    logic signed [DATA_W-1:0] s;
    s = p + DATA_W'(32768);
    return s >>> FRAC_W;
  endfunction

  state_e state_q, state_d;
  logic   ent_q;

  logic [CNT_W-1:0] count_q;
  logic [PER_W-1:0] period_q;

  logic [31:0]              t_q;
  logic [2:0]               ch_q;
  logic [IDX_W-1:0]         idx_q;
  logic [FRAC_W-1:0]        f_q;
  meth_e                    meth_q;
  logic [1:0]               k_q;
  logic signed [VAL_W-1:0]  x0_q, x1_q, x2_q, x3_q;
  logic [DT_W-1:0]          dt0_q, dt1_q, dt2_q;
  logic signed [DATA_W-1:0] acc_q, tmp_q, m1_q, m2_q;

  logic                     out_valid_q;
  logic signed [VAL_W-1:0]  coord_q;
  meth_e                    out_meth_q;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic                     accept;
  logic [CNT_W-1:0]         n_c, nm1_c;
  logic [PER_W-1:0]         per_c;
  logic                     zero_case;
  logic                     clamped;
  logic [IDX_W-1:0]         idx_c;
  meth_e                    meth_c;
  logic signed [32:0]       d_c;
  logic [32:0]              absd_c;
  logic                     big_c;
  logic                     alu_state;
  logic [IDX_W-1:0]         rd_row;
  logic                     out_load;
  logic                     wr_en;
  logic [AW-1:0]            waddr, raddr;
  logic signed [VAL_W-1:0]  rdata;
  logic signed [DATA_W-1:0] x1w, x2w, x21, sat_in;
  logic signed [VAL_W-1:0]  sat_c;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    n_c       = (32'(count_q) > MAX_SAMPLES) ? CNT_W'(MAX_SAMPLES) : count_q;
    nm1_c     = n_c - 1'b1;
    per_c     = (period_q == '0) ? PER_W'(1) : period_q;
    zero_case = (n_c == '0) || (32'(channel_i) >= CHANNELS);
    clamped   = alu_rsp.res > $signed(DATA_W'(nm1_c));
    idx_c     = clamped ? nm1_c : alu_rsp.res[IDX_W-1:0];
    if (idx_c != '0 && ({1'b0, idx_c} + 2'd2) <= {1'b0, nm1_c}) begin
      meth_c = METH_CR;
    end else if (idx_c < nm1_c) begin
      meth_c = METH_LINEAR;
    end else begin
      meth_c = METH_NEAREST;
    end
    x1w = DATA_W'(x1_q);
    x2w = DATA_W'(x2_q);
    x21 = x2w - x1w;
  end

  // sample difference for the current knot
  always_comb begin
    unique case (k_q)
      2'd0:    d_c = 33'(x1_q) - 33'(x0_q);
      2'd1:    d_c = 33'(x2_q) - 33'(x1_q);
      default: d_c = 33'(x3_q) - 33'(x2_q);
    endcase
    absd_c = d_c[32] ? 33'(-d_c) : 33'(d_c);
    big_c  = absd_c[32:31] != 2'b00;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept && cmd_i == CMD_QUERY) begin
        state_d = zero_case ? S_FIN : S_DIV_T;
      end
      S_DIV_T: if (alu_rsp.done) state_d = S_DIV_F;
      S_DIV_F: if (alu_rsp.done) state_d = S_RD_A;
      S_RD_A:  state_d = S_RD_B;
      S_RD_B:  state_d = (meth_q == METH_NEAREST) ? S_FIN : S_RD_C;
      S_RD_C:  state_d = (meth_q == METH_LINEAR) ? S_H3 : S_RD_D;
      S_RD_D:  state_d = S_RD_E;
      S_RD_E:  state_d = S_K_SQ;
      S_K_SQ: begin
        if (big_c) begin
          state_d = S_K_R2;
        end else if (alu_rsp.done) begin
          state_d = S_K_R1;
        end
      end
      S_K_R1: if (alu_rsp.done) state_d = S_K_R2;
      S_K_R2: if (alu_rsp.done) state_d = (k_q == 2'd2) ? S_T1 : S_K_SQ;
      S_T1:   if (alu_rsp.done) state_d = S_T2;
      S_T2:   if (alu_rsp.done) state_d = S_T3;
      S_T3:   if (alu_rsp.done) state_d = S_T4;
      S_T4:   if (alu_rsp.done) state_d = S_T5;
      S_T5:   if (alu_rsp.done) state_d = S_T6;
      S_T6:   if (alu_rsp.done) state_d = S_T7;
      S_T7:   if (alu_rsp.done) state_d = S_T8;
      S_T8:   if (alu_rsp.done) state_d = S_CO;
      S_CO:   state_d = S_H1;
      S_H1:   if (alu_rsp.done) state_d = S_H2;
      S_H2:   if (alu_rsp.done) state_d = S_H3;
      S_H3:   if (alu_rsp.done) state_d = S_FIN;
      S_FIN:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer: unit request and read row
  always_comb begin
    alu_state   = 1'b1;
    alu_req.op  = ALU_MUL;
    alu_req.a   = acc_q;
    alu_req.b   = DATA_W'(f_q);
    rd_row      = idx_q;
    unique case (state_q)
      S_DIV_T: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = DATA_W'(t_q);
        alu_req.b  = DATA_W'(per_c);
      end
      S_DIV_F: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = tmp_q <<< FRAC_W;
        alu_req.b  = DATA_W'(per_c);
      end
      S_K_SQ: begin
        alu_req.a = DATA_W'(absd_c);
        alu_req.b = DATA_W'(absd_c);
      end
      S_K_R1: begin
        alu_req.op = ALU_SQRT;
        alu_req.a  = tmp_q + (DATA_W'(1) <<< 32);
      end
      S_K_R2: begin
        alu_req.op = ALU_SQRT;
        alu_req.a  = tmp_q <<< FRAC_W;
      end
      S_T1: begin
        alu_req.a = x1w - DATA_W'(x0_q);
        alu_req.b = DATA_W'(dt1_q);
      end
      S_T2: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = tmp_q;
        alu_req.b  = DATA_W'(dt0_q);
      end
      S_T3: begin
        alu_req.a = x2w - DATA_W'(x0_q);
        alu_req.b = DATA_W'(dt1_q);
      end
      S_T4: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = tmp_q;
        alu_req.b  = DATA_W'(dt0_q) + DATA_W'(dt1_q);
      end
      S_T5: begin
        alu_req.a = DATA_W'(x3_q) - x1w;
        alu_req.b = DATA_W'(dt1_q);
      end
      S_T6: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = tmp_q;
        alu_req.b  = DATA_W'(dt1_q) + DATA_W'(dt2_q);
      end
      S_T7: begin
        alu_req.a = DATA_W'(x3_q) - x2w;
        alu_req.b = DATA_W'(dt1_q);
      end
      S_T8: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = tmp_q;
        alu_req.b  = DATA_W'(dt2_q);
      end
      S_H1, S_H2, S_H3: begin
        alu_req.a = acc_q;
        alu_req.b = DATA_W'(f_q);
      end
      S_RD_B: begin
        alu_state = 1'b0;
        rd_row    = idx_q + 1'b1;
      end
      S_RD_C: begin
        alu_state = 1'b0;
        rd_row    = idx_q - 1'b1;
      end
      S_RD_D: begin
        alu_state = 1'b0;
        rd_row    = idx_q + 2'd2;
      end
      default: alu_state = 1'b0;
    endcase
    alu_req.start = ent_q && alu_state && !(state_q == S_K_SQ && big_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ent_q       <= 1'b0;
      count_q     <= '0;
      period_q    <= PERIOD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ent_q   <= state_d != state_q;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SAMPLE_COUNT:  count_q  <= cfg_data_i[CNT_W-1:0];
          CFG_SAMPLE_PERIOD: period_q <= cfg_data_i[PER_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_load = state_q == S_FIN && (!out_valid_q || out_ready_i);

  always_comb begin
    sat_in = acc_q;
    if (sat_in > DATA_W'(2147483647)) begin
      sat_c = 32'sh7fff_ffff;
    end else if (sat_in < -DATA_W'(64'sd2147483648)) begin
      sat_c = 32'sh8000_0000;
    end else begin
      sat_c = sat_in[VAL_W-1:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (accept) begin
        t_q    <= query_time_ms_i;
        ch_q   <= channel_i;
        acc_q  <= '0;
        meth_q <= METH_NEAREST;
      end
      S_DIV_T: if (alu_rsp.done) begin
        idx_q  <= idx_c;
        meth_q <= meth_c;
        // past the last row the fraction is taken from period - 1
        tmp_q  <= clamped ? DATA_W'(per_c - 1'b1) : $signed(alu_rsp.rem);
      end
      S_DIV_F: if (alu_rsp.done) f_q <= alu_rsp.res[FRAC_W-1:0];
      S_RD_B: begin
        x1_q  <= rdata;
        acc_q <= DATA_W'(rdata);
      end
      S_RD_C: begin
        x2_q  <= rdata;
        acc_q <= DATA_W'(rdata) - x1w;
      end
      S_RD_D: x0_q <= rdata;
      S_RD_E: begin
        x3_q <= rdata;
        k_q  <= '0;
      end
      S_K_SQ: begin
        if (big_c) begin
          tmp_q <= DATA_W'(absd_c);
        end else if (alu_rsp.done) begin
          tmp_q <= alu_rsp.res;
        end
      end
      S_K_R1: if (alu_rsp.done) tmp_q <= alu_rsp.res;
      S_K_R2: if (alu_rsp.done) begin
        unique case (k_q)
          2'd0:    dt0_q <= alu_rsp.res[DT_W-1:0];
          2'd1:    dt1_q <= alu_rsp.res[DT_W-1:0];
          default: dt2_q <= alu_rsp.res[DT_W-1:0];
        endcase
        k_q <= k_q + 1'b1;
      end
      S_T1, S_T3, S_T5, S_T7: if (alu_rsp.done) tmp_q <= alu_rsp.res;
      S_T2: if (alu_rsp.done) m1_q <= alu_rsp.res + x21;
      S_T4: if (alu_rsp.done) m1_q <= m1_q - alu_rsp.res;
      S_T6: if (alu_rsp.done) m2_q <= x21 - alu_rsp.res;
      S_T8: if (alu_rsp.done) m2_q <= m2_q + alu_rsp.res;
      S_CO: begin
        // cubic coefficients: c3 into acc, c2 into tmp
        acc_q <= m1_q + m2_q - (x21 <<< 1);
        tmp_q <= (x21 <<< 1) + x21 - (m1_q <<< 1) - m2_q;
      end
      S_H1: if (alu_rsp.done) acc_q <= rnd16(alu_rsp.res) + tmp_q;
      S_H2: if (alu_rsp.done) acc_q <= rnd16(alu_rsp.res) + m1_q;
      S_H3: if (alu_rsp.done) acc_q <= rnd16(alu_rsp.res) + x1w;
      S_FIN: if (out_load) begin
        coord_q    <= sat_c;
        out_meth_q <= meth_q;
      end
      default: ;
    endcase
  end

  assign wr_en = accept && cmd_i == CMD_WRITE && (32'(sample_index_i) < MAX_SAMPLES)
                 && (32'(channel_i) < CHANNELS);
  assign waddr = AW'(32'(sample_index_i) * CHANNELS + 32'(channel_i));
  assign raddr = AW'(32'(rd_row) * CHANNELS + 32'(ch_q));

  stsi_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (sample_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  stsi_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign out_valid_o   = out_valid_q;
  assign coordinate_o  = coord_q;
  assign method_used_o = out_meth_q;

`ifndef SYNTH
  a_done_in_unit_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == S_DIV_T || state_q == S_DIV_F || state_q == S_K_SQ ||
                      state_q == S_K_R1 || state_q == S_K_R2 || state_q == S_T1 ||
                      state_q == S_T2 || state_q == S_T3 || state_q == S_T4 ||
                      state_q == S_T5 || state_q == S_T6 || state_q == S_T7 ||
                      state_q == S_T8 || state_q == S_H1 || state_q == S_H2 ||
                      state_q == S_H3))
    else $error("unit finished outside a waiting state");
  a_query_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i == CMD_QUERY |=> state_q != S_IDLE)
    else $error("query item did not start the sequencer");
  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i == CMD_WRITE |=> state_q == S_IDLE)
    else $error("write item started the sequencer");
  a_unit_quiet_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !alu_rsp.busy)
    else $error("unit busy while idle");
`endif

endmodule

FILE: hdl/stsi_mem.sv
// sample table ram, one write port and one registered read port
module stsi_mem import stsi_pkg::*; #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned AW    = 15
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic signed [VAL_W-1:0] wdata_i,
  input  logic [AW-1:0]           raddr_i,
  output logic signed [VAL_W-1:0] rdata_o
);

  logic signed [VAL_W-1:0] mem_q [DEPTH];
  logic signed [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/stsi_alu.sv
// shared iterative unit: shift-add multiply, restoring divide, square root
module stsi_alu import stsi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic                busy_q, busy_d;
  logic                done_q;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  alu_op_e             op_q;
  logic                neg_q;
  logic [DATA_W-1:0]   acc_q, acc_d;
  logic [DATA_W-1:0]   x_q, x_d;
  logic [DATA_W-1:0]   y_q, y_d;

  logic [DATA_W-1:0]   mag_a, mag_b;
  logic [DATA_W-1:0]   rsh_div, rsh_sq, trial;
  logic [DATA_W-1:0]   opa, opb;
  logic                sub;
  logic [DATA_W:0]     sum;
  logic                ge;
  logic                last;
  logic [DATA_W-1:0]   mag_res;

  always_comb begin
    mag_a   = req_i.a[DATA_W-1] ? DATA_W'(-req_i.a) : DATA_W'(req_i.a);
    mag_b   = req_i.b[DATA_W-1] ? DATA_W'(-req_i.b) : DATA_W'(req_i.b);
    rsh_div = {acc_q[DATA_W-2:0], x_q[DATA_W-1]};
    rsh_sq  = {acc_q[DATA_W-3:0], x_q[DATA_W-1:DATA_W-2]};
    trial   = {y_q[DATA_W-3:0], 2'b01};
    unique case (op_q)
      ALU_MUL: begin
        opa = acc_q;
        opb = x_q;
        sub = 1'b0;
        last = cnt_q == STEP_W'(MUL_STEPS - 1);
      end
      ALU_DIV: begin
        opa = rsh_div;
        opb = y_q;
        sub = 1'b1;
        last = cnt_q == STEP_W'(DIV_STEPS - 1);
      end
      ALU_SQRT: begin
        opa = rsh_sq;
        opb = trial;
        sub = 1'b1;
        last = cnt_q == STEP_W'(SQRT_STEPS - 1);
      end
      default: begin
        opa = acc_q;
        opb = x_q;
        sub = 1'b0;
        last = 1'b1;
      end
    endcase
    // one adder, carry out tells opa >= opb when subtracting
    sum = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + (DATA_W + 1)'(sub);
    ge  = sum[DATA_W];
  end

  always_comb begin
    unique case (op_q)
      ALU_MUL: begin
        acc_d = y_q[0] ? sum[DATA_W-1:0] : acc_q;
        x_d   = {x_q[DATA_W-2:0], 1'b0};
        y_d   = {1'b0, y_q[DATA_W-1:1]};
      end
      ALU_DIV: begin
        acc_d = ge ? sum[DATA_W-1:0] : rsh_div;
        x_d   = {x_q[DATA_W-2:0], ge};
        y_d   = y_q;
      end
      ALU_SQRT: begin
        acc_d = ge ? sum[DATA_W-1:0] : rsh_sq;
        x_d   = {x_q[DATA_W-3:0], 2'b00};
        y_d   = {y_q[DATA_W-2:0], ge};
      end
      default: begin
        acc_d = acc_q;
        x_d   = x_q;
        y_d   = y_q;
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      busy_d = !last;
      cnt_d  = last ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= busy_q && last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      neg_q <= (req_i.op != ALU_SQRT) && (req_i.a[DATA_W-1] ^ req_i.b[DATA_W-1]);
      acc_q <= '0;
      x_q   <= mag_a;
      y_q   <= (req_i.op == ALU_SQRT) ? '0 : mag_b;
    end else if (busy_q) begin
      acc_q <= acc_d;
      x_q   <= x_d;
      y_q   <= y_d;
    end
  end

  always_comb begin
    unique case (op_q)
      ALU_MUL:  mag_res = acc_q;
      ALU_DIV:  mag_res = x_q;
      ALU_SQRT: mag_res = y_q;
      default:  mag_res = acc_q;
    endcase
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = neg_q ? -$signed(mag_res) : $signed(mag_res);
  assign rsp_o.rem  = acc_q;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("alu started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q) else $error("alu done without a run");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0) else $error("alu step count left over");
`endif

endmodule
